// File: design/assert_macros.svh
// Assertion macros for the RTL of the receive deframer.
// Needs nothing else; files that assert take this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is held.
`define ASSERT_CLK_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/uerd_pkg.sv
// Shared types and constants of the receive deframer.
// No dependencies; used by uerd_core and usb_ethernet_rx_deframer.
`default_nettype none

package uerd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned LeftW  = 12;
    localparam int unsigned TrailW = 3;

    localparam logic [LeftW-1:0]  HdrOverhead = 12'd7;
    localparam logic [15:0]       CrcBytes    = 16'd4;
    localparam logic [ByteW-1:0]  StatusMask  = 8'hbf;

    typedef enum logic [2:0] {
        RC_PAYLOAD    = 3'd0,
        RC_SHORT      = 3'd1,
        RC_BAD_STATUS = 3'd2,
        RC_TOO_LONG   = 3'd3,
        RC_EMPTY      = 3'd4
    } result_code_t;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             frame_end;
        result_code_t     code;
    } uerd_result_t;

endpackage

`default_nettype wire

// File: design/usb_ethernet_rx_deframer.sv
// Receive deframer for a length-prefixed USB Ethernet transfer buffer: top level.
// Depends on uerd_pkg and uerd_core.
//
// Takes one byte of a received transfer buffer per item, together with the
// count of bytes left in that buffer (1 on the buffer's last byte). Each frame
// opens with a status byte and a little-endian 16-bit length that counts a
// 4-byte CRC; the payload bytes come out one per item with m_tlast on the last
// one, and the CRC plus one pad byte after an odd payload are swallowed. A
// header fault (buffer under 7 bytes at the status byte, a status with any of
// bits 0xbf set, or a length that overruns the buffer) yields one error item
// and the rest of the buffer is discarded; a zero-length payload yields an
// empty-frame marker. Error and marker items carry a zero data byte and
// m_tlast high. The last byte of a buffer always resynchronizes to a header.
// Rate: one item per clock while m_tready does not stall the output. An item
// waits in the input register, then the parser state and the result
// register update together to put its result on m_*. Bytes that make no
// result (header, CRC, pad, dropped) leave nothing on the output side.
`default_nettype none

module usb_ethernet_rx_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] rx_byte, [19:8] bytes_left, [23:20] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast,
    output logic [2:0]       m_tuser    // [2:0] result_code
);

    logic                            in_valid_reg, in_valid_next;
    logic [uerd_pkg::ByteW-1:0]      in_byte_reg;
    logic [uerd_pkg::LeftW-1:0]      in_left_reg;

    logic                            advance;
    logic                            res_valid;
    uerd_pkg::uerd_result_t          res;

    // the parse stage moves whenever the result register is free or draining
    assign advance  = !res_valid || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // hold the captured item until the parse stage takes it
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[7:0];
            in_left_reg <= s_tdata[19:8];
        end
    end

    uerd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .item_valid (in_valid_reg),
        .item_byte  (in_byte_reg),
        .item_left  (in_left_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = res.out_byte;
    assign m_tlast  = res.frame_end;
    assign m_tuser  = res.code;

endmodule

`default_nettype wire

// File: design/uerd_core.sv
// Frame parser state and result register of the receive deframer.
// Depends on uerd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module uerd_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        advance,
    input  wire logic                        item_valid,
    input  wire logic [uerd_pkg::ByteW-1:0]  item_byte,
    input  wire logic [uerd_pkg::LeftW-1:0]  item_left,
    output logic                             res_valid,
    output uerd_pkg::uerd_result_t           res
);

    typedef enum logic [2:0] {
        PH_STATUS, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_TRAILER, PH_DROP
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [uerd_pkg::LeftW-1:0]      start_left_reg, start_left_next;
    logic [uerd_pkg::ByteW-1:0]      len_low_reg, len_low_next;
    logic [uerd_pkg::LeftW-1:0]      pay_left_reg, pay_left_next;
    logic [uerd_pkg::TrailW-1:0]     trail_left_reg, trail_left_next;
    logic                            res_valid_reg, res_valid_next;
    uerd_pkg::uerd_result_t          res_reg, res_next;

    logic                            step;
    logic [15:0]                     total_len;
    logic [15:0]                     pay_len;
    logic [uerd_pkg::LeftW-1:0]      room;
    logic [uerd_pkg::LeftW-1:0]      pay_dec;
    logic [uerd_pkg::TrailW-1:0]     trail_dec;
    logic                            has_res;

    assign step      = advance && item_valid;
    assign total_len = {item_byte, len_low_reg};
    assign pay_len   = total_len - uerd_pkg::CrcBytes;
    assign room      = (start_left_reg >= uerd_pkg::HdrOverhead) ?
                       start_left_reg - uerd_pkg::HdrOverhead : '0;
    assign pay_dec   = pay_left_reg - 12'd1;
    assign trail_dec = (trail_left_reg != '0) ? trail_left_reg - 3'd1 : trail_left_reg;

    always_comb begin
        phase_next      = phase_reg;
        start_left_next = start_left_reg;
        len_low_next    = len_low_reg;
        pay_left_next   = pay_left_reg;
        trail_left_next = trail_left_reg;
        has_res         = 1'b0;
        res_next        = '{out_byte: '0, frame_end: 1'b1, code: uerd_pkg::RC_PAYLOAD};

        unique case (phase_reg)
            PH_STATUS: begin
                start_left_next = item_left;
                if (item_left < uerd_pkg::HdrOverhead) begin
                    has_res       = 1'b1;
                    res_next.code = uerd_pkg::RC_SHORT;
                    phase_next    = PH_DROP;
                end else if ((item_byte & uerd_pkg::StatusMask) != '0) begin
                    has_res       = 1'b1;
                    res_next.code = uerd_pkg::RC_BAD_STATUS;
                    phase_next    = PH_DROP;
                end else begin
                    phase_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                len_low_next = item_byte;
                phase_next   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                if (pay_len > {4'd0, room}) begin
                    has_res       = 1'b1;
                    res_next.code = uerd_pkg::RC_TOO_LONG;
                    phase_next    = PH_DROP;
                end else if (pay_len == '0) begin
                    has_res         = 1'b1;
                    res_next.code   = uerd_pkg::RC_EMPTY;
                    trail_left_next = uerd_pkg::CrcBytes[uerd_pkg::TrailW-1:0];
                    phase_next      = PH_TRAILER;
                end else begin
                    pay_left_next   = pay_len[uerd_pkg::LeftW-1:0];
                    trail_left_next = uerd_pkg::CrcBytes[uerd_pkg::TrailW-1:0]
                                      + {2'd0, pay_len[0]};
                    phase_next      = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                pay_left_next      = pay_dec;
                has_res            = 1'b1;
                res_next.out_byte  = item_byte;
                res_next.frame_end = (pay_dec == '0);
                if (pay_dec == '0) begin
                    phase_next = PH_TRAILER;
                end
            end
            PH_TRAILER: begin
                trail_left_next = trail_dec;
                if (trail_dec == '0) begin
                    phase_next = PH_STATUS;
                end
            end
            PH_DROP: begin
                phase_next = PH_DROP;
            end
            default: begin
                phase_next = PH_STATUS;
            end
        endcase

        // buffer end cuts off whatever is in progress
        if (item_left <= 12'd1) begin
            phase_next      = PH_STATUS;
            pay_left_next   = '0;
            trail_left_next = '0;
        end

        res_valid_next = res_valid_reg;
        if (advance) begin
            res_valid_next = item_valid && has_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_STATUS;
            start_left_reg <= '0;
            len_low_reg    <= '0;
            pay_left_reg   <= '0;
            trail_left_reg <= '0;
            res_valid_reg  <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (step) begin
                phase_reg      <= phase_next;
                start_left_reg <= start_left_next;
                len_low_reg    <= len_low_next;
                pay_left_reg   <= pay_left_next;
                trail_left_reg <= trail_left_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `ASSERT_CLK_RST(a_marker_is_zero_end, aclk, aresetn,
        res_valid_reg && (res_reg.code != uerd_pkg::RC_PAYLOAD) |->
            (res_reg.out_byte == '0) && res_reg.frame_end,
        "error or empty marker carries data or lacks frame end")
    `ASSERT_CLK_RST(a_payload_count_live, aclk, aresetn,
        (phase_reg == PH_PAYLOAD) |-> (pay_left_reg != '0),
        "payload phase with no bytes left")
    `ASSERT_CLK_RST(a_buffer_end_resync, aclk, aresetn,
        step && (item_left <= 12'd1) |=> (phase_reg == PH_STATUS),
        "buffer end did not return to header parsing")

endmodule

`default_nettype wire
